[hw/rtl/drd_pkg.sv]
// drd_pkg: shared types, codes and a helper function of the detector response decoder
// no dependencies
package drd_pkg;

    localparam int MaxUpd = 5;
    localparam int CntW   = 3;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  msg_type;
        logic [31:0] data_word;
        logic [3:0]  msg_len;
        logic        timeout_cmd_valid;
        logic [3:0]  timeout_command;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  target;
        logic [31:0] value;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [4:0]  target;
        logic [31:0] value;
    } upd_t;

    // register indexes
    localparam logic [1:0] RegHours   = 2'd0;
    localparam logic [1:0] RegTempOff = 2'd1;
    localparam logic [1:0] RegInvVolt = 2'd2;

    // type codes
    localparam logic [3:0] CodeStatus = 4'd2;
    localparam logic [3:0] CodeSerial = 4'd4;
    localparam logic [3:0] CodeOpTime = 4'd9;
    localparam logic [3:0] CodeSmoke  = 4'd11;
    localparam logic [3:0] CodeBatt   = 4'd12;
    localparam logic [3:0] CodeCnt1   = 4'd13;
    localparam logic [3:0] CodeCnt2   = 4'd14;

    localparam logic [4:0] TgtFlag   = 5'd0;
    localparam logic [4:0] TgtSerial = 5'd1;
    localparam logic [4:0] TgtOpTime = 5'd2;
    localparam logic [4:0] TgtSmoke  = 5'd3;
    localparam logic [4:0] TgtVolt   = 5'd6;
    localparam logic [4:0] TgtTemp   = 5'd7;
    localparam logic [4:0] TgtCnt1   = 5'd8;
    localparam logic [4:0] TgtCnt2   = 5'd12;
    localparam logic [4:0] TgtAlarm  = 5'd14;
    localparam logic [4:0] TgtButton = 5'd15;
    localparam logic [4:0] TgtFault  = 5'd16;

    // item kinds, selected in the first stage
    typedef enum logic [2:0] {
        KindNone, KindSerial, KindOpTime, KindSmoke, KindBatt, KindCnt, KindStatus
    } kind_t;

    // knx two-byte float of a value already saturated to 28 bits signed;
    // the exponent follows from the highest bit that differs from the sign
    function automatic logic [15:0] knx_float(input logic signed [27:0] v);
        logic [3:0]          e;
        logic signed [27:0]  m;
        logic [11:0]         u;
        e = 4'd0;
        for (int k = 15; k >= 1; k--) begin
            if (e == 4'd0 && (v[10 + k] != v[27])) begin
                e = k[3:0];
            end
        end
        // arithmetic shift floors, which matches the model for both signs
        m = v >>> e;
        u = m[11:0];
        return {u[11], e, u[10:0]};
    endfunction

endpackage

[hw/rtl/drd_decode.sv]
// drd_decode: stage one and two, classifies a word and forms raw arithmetic
// depends on drd_pkg
module drd_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_v,
    input  drd_pkg::in_word_t  in_w,
    input  logic               adv,
    input  logic               hours_mode,
    input  logic signed [7:0]  temp_offset,
    input  logic signed [26:0] inv_volt,
    output logic               s2_v,
    output drd_pkg::kind_t     s2_kind,
    output logic               s2_tmo,
    output logic [31:0]        s2_w,
    output logic [29:0]        s2_op,
    output logic signed [35:0] s2_a,
    output logic signed [35:0] s2_b
);
    import drd_pkg::*;

    logic        s1_v_reg;
    kind_t       s1_kind_reg;
    logic        s1_tmo_reg;
    logic [31:0] s1_w_reg;
    logic        s1_inv_reg;
    kind_t       kind_next;
    logic [7:0]  ty;
    logic [3:0]  code;

    // classify the incoming word
    always_comb
    begin
        ty = (in_w.msg_type == 8'h82) ? 8'hC2 : in_w.msg_type;
        code = in_w.cmd ? in_w.timeout_command : ty[3:0];
        kind_next = KindNone;
        if (!in_w.cmd) begin
            if (ty[7:4] == 4'hC
                && in_w.msg_len == ((code == CodeCnt2) ? 4'd3 : 4'd5)) begin
                case (code)
                    CodeSerial: kind_next = KindSerial;
                    CodeOpTime: kind_next = KindOpTime;
                    CodeSmoke:  kind_next = KindSmoke;
                    CodeBatt:   kind_next = KindBatt;
                    CodeCnt1, CodeCnt2: kind_next = KindCnt;
                    CodeStatus: kind_next = KindStatus;
                    default:    kind_next = KindNone;
                endcase
            end
        end else if (in_w.timeout_cmd_valid) begin
            case (code)
                CodeSerial: kind_next = KindSerial;
                CodeOpTime: kind_next = KindOpTime;
                CodeSmoke:  kind_next = KindSmoke;
                CodeBatt:   kind_next = KindBatt;
                CodeCnt1, CodeCnt2: kind_next = KindCnt;
                default:    kind_next = KindNone;
            endcase
        end
    end

    // stage one registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_v_reg <= 1'b0;
        end else if (adv) begin
            s1_v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_kind_reg <= kind_next;
            s1_tmo_reg  <= in_w.cmd;
            // counts one vs two are told apart by bit 0 of the code
            s1_w_reg    <= in_w.data_word;
            s1_inv_reg  <= code[0];
        end
    end

    // stage two: products and hour conversion
    logic               s2_v_reg;
    kind_t              s2_kind_reg;
    logic               s2_tmo_reg;
    logic [31:0]        s2_w_reg;
    logic [29:0]        s2_op_reg;
    logic signed [35:0] s2_a_reg;
    logic signed [35:0] s2_b_reg;
    logic [15:0]        hi16;
    logic [29:0]        secs;
    logic [60:0]        hrs_prod;
    logic [46:0]        volt_prod;

    always_comb
    begin
        hi16 = s1_w_reg[31:16];
        secs = s1_w_reg[31:2];
        // secs / 3600 by reciprocal: ceil(2^42/3600) is exact for 30-bit inputs
        hrs_prod = 61'(secs) * 61'd1221679587;
        // hi16 * 9184 / 5 by reciprocal: ceil(9184 * 2^20 / 5) is exact for 16 bits
        volt_prod = 47'(hi16) * 47'd1926024397;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_v_reg <= 1'b0;
        end else if (adv) begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s2_kind_reg <= s1_kind_reg;
            s2_tmo_reg  <= s1_tmo_reg;
            s2_w_reg    <= s1_w_reg;
            if (s1_kind_reg == KindCnt) begin
                s2_op_reg <= {29'd0, s1_inv_reg};
            end else begin
                s2_op_reg <= hours_mode ? 30'(hrs_prod >> 42) : secs;
            end
            if (s1_kind_reg == KindSmoke) begin
                s2_a_reg <= 36'(hi16) * 36'sd330;
            end else if (hi16 == 16'd1) begin
                s2_a_reg <= 36'(inv_volt);
            end else begin
                s2_a_reg <= 36'(volt_prod >> 20);
            end
            s2_b_reg <= 36'(s1_w_reg[15:8]) * 36'sd25 + 36'(s1_w_reg[7:0]) * 36'sd25
                        - 36'sd2000 + 36'(temp_offset) * 36'sd10;
        end
    end

    // for the counts kind s2_op carries the code lsb instead of a time
    assign s2_v    = s2_v_reg;
    assign s2_kind = s2_kind_reg;
    assign s2_tmo  = s2_tmo_reg;
    assign s2_w    = s2_w_reg;
    assign s2_op   = s2_op_reg;
    assign s2_a    = s2_a_reg;
    assign s2_b    = s2_b_reg;
endmodule

[hw/rtl/drd_format.sv]
// drd_format: stage three, scaling and float encoding into a list of updates
// depends on drd_pkg
module drd_format (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               s2_v,
    input  drd_pkg::kind_t     s2_kind,
    input  logic               s2_tmo,
    input  logic [31:0]        s2_w,
    input  logic [29:0]        s2_op,
    input  logic signed [35:0] s2_a,
    input  logic signed [35:0] s2_b,
    output logic               s3_v,
    output drd_pkg::upd_t      s3_upd [drd_pkg::MaxUpd],
    output logic [drd_pkg::CntW-1:0] s3_cnt
);
    import drd_pkg::*;

    logic               v_reg;
    upd_t               upd_reg [MaxUpd];
    logic [CntW-1:0]    cnt_reg;
    upd_t               upd_next [MaxUpd];
    logic [CntW-1:0]    cnt_next;
    logic signed [35:0] volt;
    logic signed [35:0] smoke;
    logic [15:0]        fv;
    logic [15:0]        fs;
    logic [15:0]        ft;
    logic [7:0]         b0, b1, b2, b3;
    logic [4:0]         alarm;
    logic [4:0]         flt;
    logic [31:0]        ones;

    function automatic logic signed [27:0] sat(input logic signed [35:0] x);
        if (x > 36'sd67076096) begin
            return 28'sd67076096;
        end else if (x < -36'sd67108864) begin
            return -28'sd67108864;
        end
        return x[27:0];
    endfunction

    // build the update list
    always_comb
    begin
        b0 = s2_w[31:24];
        b1 = s2_w[23:16];
        b2 = s2_w[15:8];
        b3 = s2_w[7:0];
        ones = '1;
        // voltage already scaled, or the invalid value as is
        smoke = s2_a >>> 10;
        volt = s2_a;
        fs = knx_float(sat(smoke));
        fv = knx_float(sat(volt));
        ft = knx_float(sat(s2_b));
        alarm = '0;
        if (b0[4] || b1[2] || b1[3]) alarm[0] = 1'b1;
        if (b1[5] || b1[6]) alarm[1] = 1'b1;
        if (b1[4]) alarm[2] = 1'b1;
        if (b1[7]) alarm[3] = 1'b1;
        flt = '0;
        if (b1[0]) flt[0] = 1'b1;
        if (b0[1]) begin
            if (b3[2]) flt[1] = 1'b1;
            if (b3[4]) flt[2] = 1'b1;
            if (b3[1] || b3[3]) flt[3] = 1'b1;
        end
        if (b0[0]) flt[4] = 1'b1;
        for (int i = 0; i < MaxUpd; i++) begin
            upd_next[i] = '0;
        end
        upd_next[0] = '{TgtFlag, {31'd0, s2_tmo}};
        cnt_next = 3'd1;
        case (s2_kind)
            KindSerial:
            begin
                upd_next[1] = '{TgtSerial, s2_tmo ? 32'd0 : s2_w};
                cnt_next = 3'd2;
            end
            KindOpTime:
            begin
                upd_next[1] = '{TgtOpTime, s2_tmo ? 32'd0 : {2'd0, s2_op}};
                cnt_next = 3'd2;
            end
            KindSmoke:
            begin
                upd_next[1] = '{TgtSmoke, s2_tmo ? ones : {16'd0, fs}};
                upd_next[2] = '{5'd4, s2_tmo ? ones : {24'd0, b2}};
                upd_next[3] = '{5'd5, s2_tmo ? ones : {24'd0, b3}};
                cnt_next = 3'd4;
            end
            KindBatt:
            begin
                upd_next[1] = '{TgtVolt, s2_tmo ? 32'd0 : {16'd0, fv}};
                upd_next[2] = '{TgtTemp, s2_tmo ? 32'd0 : {16'd0, ft}};
                cnt_next = 3'd3;
            end
            KindCnt:
            begin
                // bit 0 of s2_op holds the code lsb: 1 counts one, 0 two
                if (s2_op[0]) begin
                    upd_next[1] = '{TgtCnt1, s2_tmo ? ones : {24'd0, b0}};
                    upd_next[2] = '{5'd9, s2_tmo ? ones : {24'd0, b1}};
                    upd_next[3] = '{5'd10, s2_tmo ? ones : {24'd0, b2}};
                    upd_next[4] = '{5'd11, s2_tmo ? ones : {24'd0, b3}};
                    cnt_next = 3'd5;
                end else begin
                    upd_next[1] = '{TgtCnt2, s2_tmo ? ones : {24'd0, b0}};
                    upd_next[2] = '{5'd13, s2_tmo ? ones : {24'd0, b1}};
                    cnt_next = 3'd3;
                end
            end
            KindStatus:
            begin
                upd_next[1] = '{TgtAlarm, {27'd0, alarm}};
                if (b0[3]) begin
                    upd_next[2] = '{TgtButton, 32'd1};
                    upd_next[3] = '{TgtFault, {27'd0, flt}};
                    cnt_next = 3'd4;
                end else begin
                    upd_next[2] = '{TgtFault, {27'd0, flt}};
                    cnt_next = 3'd3;
                end
            end
            default:
            begin
                cnt_next = 3'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= s2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            upd_reg <= upd_next;
            cnt_reg <= cnt_next;
        end
    end

    assign s3_v   = v_reg;
    assign s3_upd = upd_reg;
    assign s3_cnt = cnt_reg;
endmodule

[hw/rtl/detector_response_decoder.sv]
// detector_response_decoder: top level, config registers, pipeline and output sequencer
// depends on drd_pkg, drd_decode, drd_format
//
// Usage: an input word (response or timeout event) is offered with in_valid and
// taken when in_stall is low. Each word yields one to five output words on
// out_valid/out_stall, the first always the comm timeout flag, the final one
// marked by last. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must do so while the block is idle, the block does not enforce it.
// Pipeline: an accepted input word passes three register stages (decode one
// and two, format three), then the sequencer, before its first output word.
// Throughput: one output word per cycle while out_stall is low; an input word
// yields one to five updates; the output sequencer sets this rate. The register
// stages advance while the sequencer has room or stage three is empty; with it
// full, a receiver stall holds all stages and nothing is lost or repeated.
// Reset clears all valid bits and the configuration registers.
module detector_response_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  drd_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output drd_pkg::out_word_t  out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [26:0]         cfg_data
);
    import drd_pkg::*;

    logic               hours_reg;
    logic signed [7:0]  toff_reg;
    logic signed [26:0] inv_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hours_reg <= 1'b0;
            toff_reg  <= '0;
            inv_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                RegHours:   hours_reg <= cfg_data[0];
                RegTempOff: toff_reg  <= cfg_data[7:0];
                RegInvVolt: inv_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    logic               adv;
    logic               s2_v;
    kind_t              s2_kind;
    logic               s2_tmo;
    logic [31:0]        s2_w;
    logic [29:0]        s2_op;
    logic signed [35:0] s2_a;
    logic signed [35:0] s2_b;
    logic               s3_v;
    upd_t               s3_upd [MaxUpd];
    logic [CntW-1:0]    s3_cnt;

    drd_decode u_dec (
        .clk, .rst_n, .in_v(in_valid), .in_w(in_data), .adv,
        .hours_mode(hours_reg), .temp_offset(toff_reg), .inv_volt(inv_reg),
        .s2_v, .s2_kind, .s2_tmo, .s2_w, .s2_op, .s2_a, .s2_b
    );

    drd_format u_fmt (
        .clk, .rst_n, .adv, .s2_v, .s2_kind, .s2_tmo, .s2_w, .s2_op,
        .s2_a, .s2_b, .s3_v, .s3_upd, .s3_cnt
    );

    // output sequencer: holds one update list, emits one word per cycle while out_stall is low
    logic               q_v_reg;
    upd_t               q_upd_reg [MaxUpd];
    logic [CntW-1:0]    q_cnt_reg;
    logic [CntW-1:0]    q_idx_reg;
    logic               q_take;
    logic               q_done;

    assign q_done = out_valid && !out_stall && (q_idx_reg == q_cnt_reg - 3'd1);
    assign q_take = !q_v_reg || q_done;
    assign adv    = q_take || !s3_v;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            q_v_reg   <= 1'b0;
            q_idx_reg <= '0;
        end else begin
            if (q_take && adv) begin
                q_v_reg   <= s3_v;
                q_idx_reg <= '0;
            end else if (out_valid && !out_stall) begin
                q_idx_reg <= q_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take && adv) begin
            q_upd_reg <= s3_upd;
            q_cnt_reg <= s3_cnt;
        end
    end

    assign out_valid       = q_v_reg;
    assign out_data.target = q_upd_reg[q_idx_reg].target;
    assign out_data.value  = q_upd_reg[q_idx_reg].value;
    assign out_data.last   = (q_idx_reg == q_cnt_reg - 3'd1);

    // sequencer index never passes the list length
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        q_v_reg |-> (q_idx_reg < q_cnt_reg))
        else $error("update index beyond list");
    // the first word of every list is the comm flag
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        (q_v_reg && q_idx_reg == 3'd0) |-> (out_data.target == TgtFlag))
        else $error("list does not start with flag");
    // a held word stays the same under stall
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(q_idx_reg)))
        else $error("stalled word changed");
endmodule
